>>> rtl/core/tfl_pkg.sv
// Shared types and constants of the tuning frame link.
`default_nettype none

package tfl_pkg;

    // Frame header and function codes
    localparam logic [7:0] HDR0       = 8'hAA;
    localparam logic [7:0] HDR_SERIAL = 8'hAA;
    localparam logic [7:0] HDR_RADIO  = 8'hAF;
    localparam logic [7:0] FN_BANK0   = 8'h10;
    localparam logic [7:0] FN_BANK1   = 8'h11;
    localparam logic [7:0] FN_BANK2   = 8'h12;
    localparam logic [7:0] FN_REQUEST = 8'h02;
    localparam logic [7:0] SUB_ALL    = 8'h01;

    // Minimum count of bytes ahead of the checksum
    localparam logic [7:0] MIN_ANY_LEN   = 8'd3;
    localparam logic [7:0] MIN_REQ_LEN   = 8'd5;
    localparam logic [7:0] MIN_BANK2_LEN = 8'd10;
    localparam logic [7:0] MIN_BANK_LEN  = 8'd22;

    // Byte positions inside a received frame
    localparam logic [7:0] POS_HDR0 = 8'd0;
    localparam logic [7:0] POS_HDR1 = 8'd1;
    localparam logic [7:0] POS_FN   = 8'd2;
    localparam logic [7:0] POS_SUB  = 8'd4;
    localparam int         LOAD_BASE = 4;

    // Coefficient store
    localparam int COEF_DEPTH = 27;
    localparam int COEF_AW    = 5;
    localparam logic [4:0] BANK1_BASE = 5'd9;
    localparam logic [4:0] BANK2_BASE = 5'd18;
    localparam logic [3:0] BANK_WORDS  = 4'd9;
    localparam logic [3:0] BANK2_WORDS = 4'd3;

    // Bank numbers and pending levels
    localparam logic [1:0] BANK0 = 2'd0;
    localparam logic [1:0] BANK1 = 2'd1;
    localparam logic [1:0] BANK2 = 2'd2;
    localparam logic [1:0] LVL_IDLE   = 2'd0;
    localparam logic [1:0] LVL_SERIAL = 2'd1;
    localparam logic [1:0] LVL_RADIO  = 2'd2;

    // Output port codes
    localparam logic PORT_SERIAL = 1'b0;
    localparam logic PORT_RADIO  = 1'b1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_REQUEST = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic      valid;
        cmd_kind_t kind;
        logic [1:0] bank;
    } tfl_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/tfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tfl_front.sv
// Front part: accepts requests, gathers frames, checks them and issues commands.
`default_nettype none

module tfl_front #(
    parameter int FRAME_BYTES = 32,
    localparam int AW = $clog2(FRAME_BYTES)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              mode,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              rx_last,
    input  wire logic              tx_empty,
    input  wire logic              q_ready,
    output tfl_pkg::tfl_cmd_t      push_cmd,
    input  wire logic              load_done,
    output logic                   fs_we,
    output logic [AW-1:0]          fs_waddr,
    output logic [7:0]             fs_wdata
);

    import tfl_pkg::*;

    logic [7:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] hdr0_reg, hdr0_next;
    logic [7:0] hdr1_reg, hdr1_next;
    logic [7:0] fn_reg, fn_next;
    logic [7:0] sub_reg, sub_next;
    logic       hold_reg, hold_next;
    logic       accept;
    logic       frame_ok;

    // Hold input while the queue is full or a bank load still reads the frame store
    assign in_stall = !q_ready || hold_reg;
    assign accept   = in_valid && !in_stall;

    assign frame_ok = (sum_reg == rx_byte) && (count_reg >= MIN_ANY_LEN)
                      && (hdr0_reg == HDR0) && (hdr1_reg == HDR_RADIO);

    // Gather bytes and classify a finished frame
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        hdr0_next  = hdr0_reg;
        hdr1_next  = hdr1_reg;
        fn_next    = fn_reg;
        sub_next   = sub_reg;
        hold_next  = hold_reg;
        fs_we      = 1'b0;
        fs_waddr   = count_reg[AW-1:0];
        fs_wdata   = rx_byte;
        push_cmd.valid = 1'b0;
        push_cmd.kind  = CMD_TICK;
        push_cmd.bank  = BANK0;

        if (load_done)
        begin
            hold_next = 1'b0;
        end

        if (accept)
        begin
            if (!mode)
            begin
                if (!rx_last)
                begin
                    fs_we    = (count_reg < 8'(FRAME_BYTES));
                    sum_next = sum_reg + rx_byte;
                    if (count_reg != 8'hFF)
                    begin
                        count_next = count_reg + 8'd1;
                    end
                    if (count_reg == POS_HDR0)
                    begin
                        hdr0_next = rx_byte;
                    end
                    if (count_reg == POS_HDR1)
                    begin
                        hdr1_next = rx_byte;
                    end
                    if (count_reg == POS_FN)
                    begin
                        fn_next = rx_byte;
                    end
                    if (count_reg == POS_SUB)
                    begin
                        sub_next = rx_byte;
                    end
                end
                else
                begin
                    count_next = 8'd0;
                    sum_next   = 8'd0;
                    if (frame_ok)
                    begin
                        if (fn_reg == FN_BANK0 && count_reg >= MIN_BANK_LEN)
                        begin
                            push_cmd.valid = 1'b1;
                            push_cmd.kind  = CMD_LOAD;
                            push_cmd.bank  = BANK0;
                        end
                        else if (fn_reg == FN_BANK1 && count_reg >= MIN_BANK_LEN)
                        begin
                            push_cmd.valid = 1'b1;
                            push_cmd.kind  = CMD_LOAD;
                            push_cmd.bank  = BANK1;
                        end
                        else if (fn_reg == FN_BANK2 && count_reg >= MIN_BANK2_LEN)
                        begin
                            push_cmd.valid = 1'b1;
                            push_cmd.kind  = CMD_LOAD;
                            push_cmd.bank  = BANK2;
                        end
                        else if (fn_reg == FN_REQUEST && count_reg >= MIN_REQ_LEN
                                 && sub_reg == SUB_ALL)
                        begin
                            push_cmd.valid = 1'b1;
                            push_cmd.kind  = CMD_REQUEST;
                        end
                    end
                    if (push_cmd.valid && push_cmd.kind == CMD_LOAD)
                    begin
                        hold_next = 1'b1;
                    end
                end
            end
            else if (tx_empty)
            begin
                push_cmd.valid = 1'b1;
                push_cmd.kind  = CMD_TICK;
            end
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 8'd0;
            sum_reg   <= 8'd0;
            hold_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            hold_reg  <= hold_next;
        end
    end

    // Capture header fields
    always_ff @(posedge clk)
    begin
        hdr0_reg <= hdr0_next;
        hdr1_reg <= hdr1_next;
        fn_reg   <= fn_next;
        sub_reg  <= sub_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/tfl_queue.sv
// Short command queue between the front and the back.
`default_nettype none

module tfl_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  tfl_pkg::tfl_cmd_t push_cmd,
    output logic              ready,
    output tfl_pkg::tfl_cmd_t head,
    input  wire logic         pop
);

    import tfl_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    tfl_cmd_t        entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wptr_reg, rptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign ready   = (count_reg != CW'(QUEUE_DEPTH));
    assign do_push = push_cmd.valid && ready;
    assign do_pop  = pop && (count_reg != '0);

    // Present the oldest command
    always_comb
    begin
        head       = entry_reg[rptr_reg];
        head.valid = (count_reg != '0);
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tfl_back.sv
// Back part: loads coefficient banks, tracks pending levels and sends frames.
`default_nettype none

module tfl_back #(
    parameter int FRAME_BYTES = 32,
    localparam int AW = $clog2(FRAME_BYTES)
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  tfl_pkg::tfl_cmd_t head,
    output logic              pop,
    output logic              load_done,
    output logic              fs_re,
    output logic [AW-1:0]     fs_raddr,
    input  wire logic [7:0]   fs_rdata,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [7:0]        tx_byte,
    output logic              tx_last,
    output logic              tx_port
);

    import tfl_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'b0001,
        ST_LOAD_ADDR = 4'b0010,
        ST_LOAD_DATA = 4'b0100,
        ST_SEND      = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [1:0]             pend_reg [3];
    logic [1:0]             pend_next [3];
    logic [1:0]             bank_reg, bank_next;
    logic                   port_reg, port_next;
    logic [COEF_AW-1:0]     base_reg, base_next;
    logic [4:0]             idx_reg, idx_next;
    logic [3:0]             word_reg, word_next;
    logic [7:0]             hi_reg, hi_next;
    logic [7:0]             sum_reg, sum_next;
    logic [COEF_DEPTH-1:0]  cvld_reg, cvld_next;
    logic                   rvld_reg, rvld_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             tx_byte_reg, tx_byte_next;
    logic                   tx_last_reg, tx_last_next;
    logic                   tx_port_reg, tx_port_next;

    logic                   cr_we, cr_re;
    logic [COEF_AW-1:0]     cr_waddr, cr_raddr;
    logic [15:0]            cr_wdata, cr_rdata;
    logic [15:0]            coef;
    logic [3:0]             nwords;
    logic [4:0]             last_idx;
    logic [4:0]             load_last;
    logic                   fire;
    logic [7:0]             send_byte;
    logic                   p0, p1, p2;

    // Coefficient store
    tfl_ram #(
        .WIDTH (16),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (cr_we),
        .waddr (cr_waddr),
        .wdata (cr_wdata),
        .re    (cr_re),
        .raddr (cr_raddr),
        .rdata (cr_rdata)
    );

    assign nwords    = (bank_reg == BANK2) ? BANK2_WORDS : BANK_WORDS;
    assign last_idx  = 5'({nwords, 1'b0}) + 5'd4;
    assign load_last = 5'({nwords, 1'b0}) - 5'd1;
    assign coef      = rvld_reg ? cr_rdata : 16'h0000;
    assign fire      = (state_reg == ST_SEND) && (!out_valid_reg || !out_stall);

    assign p0 = (pend_reg[0] == LVL_SERIAL) || (pend_reg[0] == LVL_RADIO);
    assign p1 = (pend_reg[1] == LVL_SERIAL) || (pend_reg[1] == LVL_RADIO);
    assign p2 = (pend_reg[2] == LVL_SERIAL) || (pend_reg[2] == LVL_RADIO);

    // Select the byte at the current frame position
    always_comb
    begin
        if (idx_reg == 5'd0)
        begin
            send_byte = HDR0;
        end
        else if (idx_reg == 5'd1)
        begin
            send_byte = port_reg ? HDR_RADIO : HDR_SERIAL;
        end
        else if (idx_reg == 5'd2)
        begin
            send_byte = FN_BANK0 + {6'd0, bank_reg};
        end
        else if (idx_reg == 5'd3)
        begin
            send_byte = {3'd0, nwords, 1'b0};
        end
        else if (idx_reg == last_idx)
        begin
            send_byte = sum_reg;
        end
        else if (idx_reg[0])
        begin
            send_byte = coef[7:0];
        end
        else
        begin
            send_byte = coef[15:8];
        end
    end

    // Sequence commands
    always_comb
    begin
        state_next = state_reg;
        for (int b = 0; b < 3; b++)
        begin
            pend_next[b] = pend_reg[b];
        end
        bank_next      = bank_reg;
        port_next      = port_reg;
        base_next      = base_reg;
        idx_next       = idx_reg;
        word_next      = word_reg;
        hi_next        = hi_reg;
        sum_next       = sum_reg;
        cvld_next      = cvld_reg;
        rvld_next      = rvld_reg;
        tx_byte_next   = tx_byte_reg;
        tx_last_next   = tx_last_reg;
        tx_port_next   = tx_port_reg;
        out_valid_next = out_stall ? out_valid_reg : 1'b0;
        pop       = 1'b0;
        load_done = 1'b0;
        fs_re     = 1'b0;
        fs_raddr  = AW'(LOAD_BASE) + AW'(idx_reg);
        cr_we     = 1'b0;
        cr_waddr  = base_reg + COEF_AW'(idx_reg[4:1]);
        cr_wdata  = {hi_reg, fs_rdata};
        cr_re     = 1'b0;
        cr_raddr  = base_reg + COEF_AW'(word_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    idx_next  = 5'd0;
                    word_next = 4'd0;
                    sum_next  = 8'd0;
                    case (head.kind)
                        CMD_LOAD:
                        begin
                            bank_next  = head.bank;
                            base_next  = (head.bank == BANK1) ? BANK1_BASE :
                                         (head.bank == BANK2) ? BANK2_BASE : '0;
                            state_next = ST_LOAD_ADDR;
                        end
                        CMD_REQUEST:
                        begin
                            for (int b = 0; b < 3; b++)
                            begin
                                pend_next[b] = LVL_SERIAL;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (p0)
                            begin
                                bank_next    = BANK0;
                                base_next    = '0;
                                port_next    = (pend_reg[0] == LVL_RADIO);
                                pend_next[0] = (pend_reg[0] == LVL_SERIAL) ? LVL_RADIO
                                                                           : LVL_IDLE;
                                state_next   = ST_SEND;
                            end
                            else if (p1)
                            begin
                                bank_next    = BANK1;
                                base_next    = BANK1_BASE;
                                port_next    = (pend_reg[1] == LVL_RADIO);
                                pend_next[1] = LVL_IDLE;
                                state_next   = ST_SEND;
                            end
                            else if (p2)
                            begin
                                bank_next    = BANK2;
                                base_next    = BANK2_BASE;
                                port_next    = (pend_reg[2] == LVL_RADIO);
                                pend_next[2] = LVL_IDLE;
                                state_next   = ST_SEND;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_LOAD_ADDR:
            begin
                fs_re      = 1'b1;
                state_next = ST_LOAD_DATA;
            end

            ST_LOAD_DATA:
            begin
                if (!idx_reg[0])
                begin
                    hi_next = fs_rdata;
                end
                else
                begin
                    cr_we               = 1'b1;
                    cvld_next[cr_waddr] = 1'b1;
                end
                idx_next = idx_reg + 5'd1;
                if (idx_reg == load_last)
                begin
                    pend_next[bank_reg] = LVL_SERIAL;
                    load_done  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_LOAD_ADDR;
                end
            end

            ST_SEND:
            begin
                if (fire)
                begin
                    out_valid_next = 1'b1;
                    tx_byte_next   = send_byte;
                    tx_port_next   = port_reg;
                    tx_last_next   = (idx_reg == last_idx);
                    sum_next       = sum_reg + send_byte;
                    idx_next       = idx_reg + 5'd1;
                    // Fetch the next coefficient ahead of its high byte
                    if (idx_reg[0] && idx_reg >= 5'd3 && idx_reg < last_idx - 5'd2)
                    begin
                        cr_re     = 1'b1;
                        rvld_next = cvld_reg[cr_raddr];
                        word_next = word_reg + 4'd1;
                    end
                    if (idx_reg == last_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int b = 0; b < 3; b++)
            begin
                pend_reg[b] <= LVL_IDLE;
            end
            cvld_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            for (int b = 0; b < 3; b++)
            begin
                pend_reg[b] <= pend_next[b];
            end
            cvld_reg      <= cvld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold working data and the output stage
    always_ff @(posedge clk)
    begin
        bank_reg    <= bank_next;
        port_reg    <= port_next;
        base_reg    <= base_next;
        idx_reg     <= idx_next;
        word_reg    <= word_next;
        hi_reg      <= hi_next;
        sum_reg     <= sum_next;
        rvld_reg    <= rvld_next;
        tx_byte_reg <= tx_byte_next;
        tx_last_reg <= tx_last_next;
        tx_port_reg <= tx_port_next;
    end

    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign tx_last   = tx_last_reg;
    assign tx_port   = tx_port_reg;

endmodule

`default_nettype wire

>>> rtl/core/tuning_frame_link_top.sv
// Top level of the tuning frame link: front, command queue, back and frame store.
//
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, mode, rx_byte,      | request in
//          | rx_last, tx_empty                       |
//  out     | out_valid, out_stall, tx_byte, tx_last, | request out
//          | tx_port                                 |
//
// After a good bank frame the input stalls while the bank is copied from the frame
// store, a byte at a time over its single read port, and longer when a send is still
// under way ahead of the load.
// A slot tick frame goes out one byte per cycle unless stalled (23 or 11 bytes).
// Reset clears counters, pending levels and coefficient valid bits at once.
// The output register holds a stalled byte and is refilled at the edge that takes it.
`default_nettype none

module tuning_frame_link_top #(
    parameter int FRAME_BYTES = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       mode,
    input  wire logic [7:0] rx_byte,
    input  wire logic       rx_last,
    input  wire logic       tx_empty,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      tx_byte,
    output logic            tx_last,
    output logic            tx_port
);

    import tfl_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);

    tfl_cmd_t       push_cmd;
    tfl_cmd_t       head;
    logic           q_ready;
    logic           pop;
    logic           load_done;
    logic           fs_we, fs_re;
    logic [AW-1:0]  fs_waddr, fs_raddr;
    logic [7:0]     fs_wdata, fs_rdata;

    tfl_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .rx_byte   (rx_byte),
        .rx_last   (rx_last),
        .tx_empty  (tx_empty),
        .q_ready   (q_ready),
        .push_cmd  (push_cmd),
        .load_done (load_done),
        .fs_we     (fs_we),
        .fs_waddr  (fs_waddr),
        .fs_wdata  (fs_wdata)
    );

    // Frame store
    tfl_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .re    (fs_re),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    tfl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cmd (push_cmd),
        .ready    (q_ready),
        .head     (head),
        .pop      (pop)
    );

    tfl_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .load_done (load_done),
        .fs_re     (fs_re),
        .fs_raddr  (fs_raddr),
        .fs_rdata  (fs_rdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tx_byte   (tx_byte),
        .tx_last   (tx_last),
        .tx_port   (tx_port)
    );

endmodule

`default_nettype wire

>>> dv/tuning_frame_link_top_test.sv
// Self-checking testbench of the tuning frame link: framed coefficient loads and slot ticks.
`timescale 1ns / 1ps

module tuning_frame_link_top_test;
    import tfl_pkg::*;

    localparam int FRAME_BYTES   = 32;
    localparam int RANDOM_ITEMS  = 500;
    localparam int REPORT_LIMIT  = 10;
    localparam int DRAIN_CYCLES  = 60;

    // Request kinds on the input channel
    localparam logic MODE_RX   = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Receiver stall patterns
    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    typedef struct packed {
        logic       mode;
        logic [7:0] data;
        logic       last;
        logic       empty;
    } link_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       port;
    } tx_beat_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       mode      = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       rx_last   = 1'b0;
    logic       tx_empty  = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       tx_port;

    // Stimulus and expectation stores
    link_req_t  req_q[$];
    logic [7:0] body_q[$];
    tx_beat_t   tx_expect_q[$];

    // Shadow state of the link
    logic [7:0]  shadow_frame [FRAME_BYTES];
    logic [7:0]  shadow_count;
    logic [7:0]  shadow_sum;
    logic [15:0] shadow_coef [COEF_DEPTH];
    logic [1:0]  shadow_level [3];

    int mismatches    = 0;
    int beats_checked = 0;
    int frames_loaded = 0;
    int frames_sent   = 0;
    int ticks_taken   = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int stall_mode    = STALL_NONE;
    int stall_left    = 0;
    int stall_phase   = 0;

    tuning_frame_link_top #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .rx_byte  (rx_byte),
        .rx_last  (rx_last),
        .tx_empty (tx_empty),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .tx_byte  (tx_byte),
        .tx_last  (tx_last),
        .tx_port  (tx_port)
    );

    always #5 clk = ~clk;

    // Queue the bytes of one outgoing coefficient frame
    task automatic emit_bank(input logic [1:0] bank, input logic port);
        logic [7:0]  sum;
        logic [7:0]  b;
        logic [15:0] code;
        int          words;
        int          base;
        int          j;
        words = (bank == BANK2) ? int'(BANK2_WORDS) : int'(BANK_WORDS);
        base  = int'(bank) * int'(BANK_WORDS);
        sum   = 8'h00;
        for (j = 0; j < 4 + 2 * words; j++)
        begin
            case (j)
                0: b = HDR0;
                1: b = (port == PORT_RADIO) ? HDR_RADIO : HDR_SERIAL;
                2: b = FN_BANK0 + bank;
                3: b = 8'(2 * words);
                default:
                begin
                    code = shadow_coef[base + (j - 4) / 2];
                    b = ((j - 4) % 2 == 0) ? code[15:8] : code[7:0];
                end
            endcase
            tx_expect_q.push_back('{data: b, last: 1'b0, port: port});
            sum = sum + b;
        end
        tx_expect_q.push_back('{data: sum, last: 1'b1, port: port});
        frames_sent++;
    endtask

    // Advance the shadow state by one accepted request
    task automatic predict_link(input link_req_t r);
        logic [7:0] fn;
        logic [1:0] bank;
        int         words;
        int         k;
        bit         sent;
        if (r.mode == MODE_RX)
        begin
            if (!r.last)
            begin
                if (shadow_count < FRAME_BYTES)
                    shadow_frame[shadow_count] = r.data;
                shadow_sum = shadow_sum + r.data;
                if (shadow_count != 8'd255)
                    shadow_count = shadow_count + 8'd1;
            end
            else
            begin
                fn = shadow_frame[POS_FN];
                if (shadow_sum == r.data && shadow_count >= MIN_ANY_LEN &&
                    shadow_frame[POS_HDR0] == HDR0 && shadow_frame[POS_HDR1] == HDR_RADIO)
                begin
                    if (((fn == FN_BANK0 || fn == FN_BANK1) && shadow_count >= MIN_BANK_LEN) ||
                        (fn == FN_BANK2 && shadow_count >= MIN_BANK2_LEN))
                    begin
                        bank  = fn[1:0];
                        words = (bank == BANK2) ? int'(BANK2_WORDS) : int'(BANK_WORDS);
                        for (k = 0; k < words; k++)
                            shadow_coef[int'(bank) * int'(BANK_WORDS) + k] =
                                {shadow_frame[LOAD_BASE + 2 * k],
                                 shadow_frame[LOAD_BASE + 2 * k + 1]};
                        shadow_level[bank] = LVL_SERIAL;
                        frames_loaded++;
                    end
                    else if (fn == FN_REQUEST && shadow_count >= MIN_REQ_LEN &&
                             shadow_frame[POS_SUB] == SUB_ALL)
                    begin
                        for (k = 0; k < 3; k++)
                            shadow_level[k] = LVL_SERIAL;
                        frames_loaded++;
                    end
                end
                shadow_count = 8'd0;
                shadow_sum   = 8'd0;
            end
        end
        else if (r.empty)
        begin
            ticks_taken++;
            sent = 1'b0;
            for (k = 0; k < 3; k++)
            begin
                if (!sent && shadow_level[k] == LVL_SERIAL)
                begin
                    shadow_level[k] = (k == 0) ? LVL_RADIO : LVL_IDLE;
                    emit_bank(2'(k), PORT_SERIAL);
                    sent = 1'b1;
                end
                else if (!sent && shadow_level[k] == LVL_RADIO)
                begin
                    shadow_level[k] = LVL_IDLE;
                    emit_bank(2'(k), PORT_RADIO);
                    sent = 1'b1;
                end
            end
        end
    endtask

    // Compare one returned byte with the oldest expectation
    task automatic check_beat(input logic [7:0] d, input logic l, input logic p);
        tx_beat_t want;
        beats_checked++;
        if (tx_expect_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] unexpected byte %h last %b port %b", $time, d, l, p);
        end
        else
        begin
            want = tx_expect_q.pop_front();
            if (want.data !== d || want.last !== l || want.port !== p)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] byte %0d: expected %h/%b/%b got %h/%b/%b (byte/last/port)",
                             $time, beats_checked, want.data, want.last, want.port, d, l, p);
            end
        end
    endtask

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Open a frame body: header, function, spare byte
    task automatic start_frame(input logic [7:0] fn);
        body_q.delete();
        body_q.push_back(HDR0);
        body_q.push_back(HDR_RADIO);
        body_q.push_back(fn);
        body_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_bank(input logic [7:0] fn);
        logic [15:0] code;
        int          words;
        int          k;
        words = (fn == FN_BANK2) ? int'(BANK2_WORDS) : int'(BANK_WORDS);
        start_frame(fn);
        for (k = 0; k < words; k++)
        begin
            code = pick_code();
            body_q.push_back(code[15:8]);
            body_q.push_back(code[7:0]);
        end
    endtask

    task automatic pad_frame(input int n);
        repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Turn the body into requests, closing with a checksum off by sum_err
    task automatic push_frame(input logic [7:0] sum_err);
        logic [7:0] chk;
        link_req_t  r;
        chk = 8'h00;
        foreach (body_q[i])
        begin
            chk = chk + body_q[i];
            r = '{mode: MODE_RX, data: body_q[i], last: 1'b0, empty: 1'($urandom_range(0, 1))};
            req_q.push_back(r);
        end
        r = '{mode: MODE_RX, data: chk + sum_err, last: 1'b1, empty: 1'($urandom_range(0, 1))};
        req_q.push_back(r);
        body_q.delete();
    endtask

    task automatic push_tick(input logic empty);
        link_req_t r;
        r = '{mode: MODE_TICK, data: 8'($urandom_range(0, 255)),
              last: 1'($urandom_range(0, 1)), empty: empty};
        req_q.push_back(r);
    endtask

    function automatic logic [7:0] pick_bank_fn();
        case ($urandom_range(0, 2))
            0: return FN_BANK0;
            1: return FN_BANK1;
            default: return FN_BANK2;
        endcase
    endfunction

    // Present requests in bursts with random gaps, holding each until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_link(req_q.pop_front());
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (req_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    mode     <= req_q[0].mode;
                    rx_byte  <= req_q[0].data;
                    rx_last  <= req_q[0].last;
                    tx_empty <= req_q[0].empty;
                    in_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Check returned bytes and stall on a changing pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_beat(tx_byte, tx_last, tx_port);
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
                stall_left = $urandom_range(32, 256);
            end
            else
                stall_left--;
            stall_phase++;
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= ((stall_phase % 7) < 3);
            endcase
        end
    end

    // Hold reset, then release
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Guard against a hung run
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Build the stimulus, then wait for the drain and report
    initial
    begin
        int        directed_n;
        int        long_len;
        int        kind;
        int        k;
        int        target;
        logic [7:0] fn;

        foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
        foreach (shadow_coef[i]) shadow_coef[i] = 16'h0000;
        foreach (shadow_level[i]) shadow_level[i] = LVL_IDLE;
        shadow_count = 8'd0;
        shadow_sum   = 8'd0;

        // Ticks with nothing pending and with the FIFO busy
        push_tick(1'b1);
        push_tick(1'b0);
        // Bank 2 load with extreme codes, ignored tick, then a send
        start_frame(FN_BANK2);
        body_q.push_back(8'h80); body_q.push_back(8'h00);
        body_q.push_back(8'h7F); body_q.push_back(8'hFF);
        body_q.push_back(8'hFF); body_q.push_back(8'hFF);
        push_frame(8'h00);
        push_tick(1'b0);
        push_tick(1'b1);
        // Request all banks, send bank 0 once, repeat the request while it waits for radio
        start_frame(FN_REQUEST);
        body_q.push_back(SUB_ALL);
        push_frame(8'h00);
        push_tick(1'b1);
        start_frame(FN_REQUEST);
        body_q.push_back(SUB_ALL);
        push_frame(8'h00);
        repeat (5) push_tick(1'b1);
        directed_n = req_q.size();

        long_len = 0;
        while (req_q.size() < directed_n + RANDOM_ITEMS)
        begin
            // One frame far past the store size and the count limit
            if (long_len == 0 && req_q.size() > directed_n + RANDOM_ITEMS / 2)
            begin
                k = req_q.size();
                build_bank(FN_BANK1);
                pad_frame(240);
                push_frame(8'h00);
                long_len = req_q.size() - k;
            end
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                build_bank(pick_bank_fn());
                if ($urandom_range(0, 3) == 0)
                    pad_frame($urandom_range(1, 14));
                push_frame(8'h00);
            end
            else if (kind < 45)
            begin
                start_frame(FN_REQUEST);
                body_q.push_back((kind < 40) ? SUB_ALL : 8'($urandom_range(0, 255)));
                pad_frame($urandom_range(0, 2));
                push_frame(8'h00);
            end
            else if (kind < 70)
            begin
                repeat ($urandom_range(1, 3)) push_tick(1'($urandom_range(0, 4) != 0));
            end
            else if (kind < 90)
            begin
                case ($urandom_range(0, 4))
                    0:
                    begin
                        build_bank(pick_bank_fn());
                        push_frame(8'($urandom_range(1, 255)));
                    end
                    1:
                    begin
                        build_bank(pick_bank_fn());
                        k = $urandom_range(0, 1);
                        body_q[k] = body_q[k] ^ (8'd1 << $urandom_range(0, 7));
                        push_frame(8'h00);
                    end
                    2:
                    begin
                        fn = ($urandom_range(0, 3) == 0) ? FN_REQUEST : pick_bank_fn();
                        if (fn == FN_REQUEST)
                        begin
                            start_frame(fn);
                            body_q.push_back(SUB_ALL);
                            target = $urandom_range(3, 4);
                        end
                        else
                        begin
                            build_bank(fn);
                            target = ((fn == FN_BANK2) ? int'(MIN_BANK2_LEN) : int'(MIN_BANK_LEN))
                                     - $urandom_range(1, 4);
                        end
                        while (body_q.size() > target)
                            void'(body_q.pop_back());
                        push_frame(8'h00);
                    end
                    3:
                    begin
                        start_frame(8'($urandom_range(0, 255)));
                        pad_frame(18);
                        push_frame(8'h00);
                    end
                    default:
                    begin
                        body_q.delete();
                        repeat ($urandom_range(0, 2)) body_q.push_back(8'($urandom_range(0, 255)));
                        if (body_q.size() > 0 && $urandom_range(0, 1) == 1)
                            body_q[0] = HDR0;
                        push_frame(8'h00);
                    end
                endcase
            end
            else
            begin
                // Noise bytes, then a closing byte to resync the framing
                repeat ($urandom_range(1, 8))
                    req_q.push_back('{mode: MODE_RX, data: 8'($urandom_range(0, 255)),
                                      last: 1'($urandom_range(0, 1)),
                                      empty: 1'($urandom_range(0, 1))});
                req_q.push_back('{mode: MODE_RX, data: 8'($urandom_range(0, 255)),
                                  last: 1'b1, empty: 1'($urandom_range(0, 1))});
            end
        end

        // Drain: all requests taken, all expected bytes returned, then idle a while
        while (req_q.size() != 0)
            @(posedge clk);
        while (tx_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d good frames, %0d taken slot ticks and %0d returned frames,",
                 frames_loaded, ticks_taken, frames_sent);
        $display("with %0d bytes checked and %0d mismatches.", beats_checked, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
